// ----- rtl/core/ringtone_text_note_parser_assert.svh -----
// assertion macros used by the checker file
`ifndef RINGTONE_TEXT_NOTE_PARSER_ASSERT_SVH
`define RINGTONE_TEXT_NOTE_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RTTTL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtttl check failed");

// next-cycle implication, disabled during reset
`define RTTTL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtttl check failed");

`endif

// ----- rtl/core/rtttl_pkg.sv -----
package rtttl_pkg;

  // item formats
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       play_enable;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  octave;
    logic [3:0]  semitone;
    logic [18:0] duration_ms;
    logic        tune_end;
  } out_item_t;

  // parser phases
  typedef enum logic [2:0] {
    PH_NAME = 3'd0,
    PH_HDR  = 3'd1,
    PH_DUR  = 3'd2,
    PH_OCT  = 3'd3,
    PH_BPM  = 3'd4,
    PH_LEN  = 3'd5,
    PH_TAIL = 3'd6
  } phase_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_HOLD = 2'd2
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic take_item;
    logic load_out;
    logic write_whole;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic note_pend;
    logic div_done;
  } dp_status_t;

  // divider sizes
  localparam int DIV_W     = 18;
  localparam int DVS_W     = 10;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // reset values and limits
  localparam logic [3:0]       OCTAVE_ADD   = 4'd0;
  localparam logic [7:0]       DEF_LEN      = 8'd4;
  localparam logic [3:0]       DEF_OCT      = 4'd6;
  localparam logic [9:0]       BPM_FALLBACK = 10'd63;
  localparam logic [DIV_W-1:0] WHOLE_RESET  = 18'd3808;
  localparam logic [DIV_W-1:0] MINUTE_MS    = 18'd60000;
  localparam logic [13:0]      ACC_MAX      = 14'd999;
  localparam logic [11:0]      LEN_MAX      = 12'd255;
  localparam logic [3:0]       OCT_MIN      = 4'd3;
  localparam logic [3:0]       OCT_MAX      = 4'd7;

  // characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_X     = 8'h78;

  // note letter to semitone, anything else is a rest
  function automatic logic [3:0] semi_of(input logic [7:0] c);
    logic [3:0] s;
    unique case (c)
      CH_A:    s = 4'd10;
      CH_B:    s = 4'd12;
      CH_C:    s = 4'd1;
      CH_D:    s = 4'd3;
      CH_E:    s = 4'd5;
      CH_F:    s = 4'd6;
      CH_G:    s = 4'd8;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/ringtone_text_note_parser.sv -----
// channel  direction  payload                                   handshake
// in_      input      char_code, last_char, play_enable         in_valid / in_stall
// out_     output     octave, semitone, duration_ms, tune_end   out_valid / out_stall
//
// a character that emits no note and commits no tempo needs no division
// a note or a tempo commit runs through the shared
// 18-step restoring divider (one quotient bit per cycle)
// synchronous active-low reset returns the parser to name skipping
// a finished note waits in the output register, input taken; the next stalls input
module ringtone_text_note_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rtttl_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rtttl_pkg::out_item_t out_item
);

  rtttl_pkg::ctrl_cmd_t  cmd;
  rtttl_pkg::dp_status_t sts;

  rtttl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rtttl_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

// ----- rtl/core/rtttl_div.sv -----
module rtttl_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [rtttl_pkg::DIV_W-1:0]        dividend,
  input  logic [rtttl_pkg::DVS_W-1:0]        divisor,
  output logic [rtttl_pkg::DIV_W-1:0]        quotient,
  output logic                               done
);

  logic                                 busy_r, busy_nxt;
  logic                                 done_r, done_nxt;
  logic [rtttl_pkg::DIV_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [rtttl_pkg::DIV_W-1:0]          quo_r, quo_nxt;
  logic [rtttl_pkg::DVS_W-1:0]          rem_r, rem_nxt;
  logic [rtttl_pkg::DVS_W-1:0]          dvs_r, dvs_nxt;
  logic [rtttl_pkg::DVS_W:0]            rem_sh;
  logic [rtttl_pkg::DVS_W:0]            rem_sub;
  logic                                 ge;

  // one restoring step per cycle, msb first
  always_comb begin
    rem_sh  = {rem_r, quo_r[rtttl_pkg::DIV_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = rtttl_pkg::DIV_CNT_W'(rtttl_pkg::DIV_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[rtttl_pkg::DIV_W-2:0], ge};
      rem_nxt = ge ? rem_sub[rtttl_pkg::DVS_W-1:0] : rem_sh[rtttl_pkg::DVS_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == rtttl_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ----- rtl/core/rtttl_dp.sv -----
module rtttl_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtttl_pkg::in_item_t   in_item,
  input  rtttl_pkg::ctrl_cmd_t  cmd,
  output rtttl_pkg::dp_status_t sts,
  output rtttl_pkg::out_item_t  out_item
);

  rtttl_pkg::phase_t             phase_r, phase_nxt, phase_m;
  logic [7:0]                    dlen_r, dlen_nxt, dlen_m;
  logic [3:0]                    doct_r, doct_nxt, doct_m;
  logic [rtttl_pkg::DIV_W-1:0]   whole_r, whole_nxt;
  logic [9:0]                    acc_r, acc_nxt, acc_m;
  logic [3:0]                    psemi_r, psemi_nxt, psemi_m;
  logic                          pdot_r, pdot_nxt, pdot_m;
  logic [3:0]                    poct_r, poct_nxt, poct_m;
  logic [7:0]                    plen_r, plen_nxt, plen_m;
  logic                          note_r, note_nxt;
  logic [3:0]                    res_oct_r;
  logic [3:0]                    res_semi_r;
  logic                          res_dot_r;
  logic                          res_end_r;
  rtttl_pkg::out_item_t          out_r;

  logic [7:0]                    c;
  logic                          digit, blank;
  logic [3:0]                    dv;
  logic [13:0]                   acc_mul;
  logic [11:0]                   len_mul;
  logic                          emit, tune_end, bpm_commit;
  logic [9:0]                    bpm_v;
  logic [7:0]                    len_sel;
  logic [rtttl_pkg::DIV_W-1:0]   div_dvd;
  logic [rtttl_pkg::DVS_W-1:0]   div_dvs;
  logic [rtttl_pkg::DIV_W-1:0]   div_q;
  logic                          div_done;
  logic                          div_start;
  logic [18:0]                   dur;

  // character classes
  always_comb begin
    c = in_item.char_code;
    if (c >= rtttl_pkg::CH_UP_A && c <= rtttl_pkg::CH_UP_Z) c = c | 8'h20;
    digit = (c >= rtttl_pkg::CH_ZERO && c <= rtttl_pkg::CH_NINE);
    dv    = digit ? c[3:0] : 4'd0;
    blank = (c == rtttl_pkg::CH_SPACE) || (c == rtttl_pkg::CH_TAB) ||
            (c == rtttl_pkg::CH_CR) || (c == rtttl_pkg::CH_LF);
    acc_mul = 14'(acc_r) * 14'd10 + 14'(dv);
    len_mul = 12'(plen_r) * 12'd10 + 12'(dv);
    bpm_v   = (acc_r == 10'd0) ? rtttl_pkg::BPM_FALLBACK : acc_r;
  end

  // per-character parse step
  always_comb begin
    phase_m    = phase_r;
    dlen_m     = dlen_r;
    doct_m     = doct_r;
    acc_m      = acc_r;
    psemi_m    = psemi_r;
    pdot_m     = pdot_r;
    poct_m     = poct_r;
    plen_m     = plen_r;
    emit       = 1'b0;
    tune_end   = 1'b0;
    bpm_commit = 1'b0;
    if (in_item.play_enable) begin
      unique case (phase_r)
        rtttl_pkg::PH_NAME: begin
          if (c == rtttl_pkg::CH_COLON) phase_m = rtttl_pkg::PH_HDR;
        end
        rtttl_pkg::PH_HDR: begin
          acc_m = '0;
          priority if (c == rtttl_pkg::CH_D) phase_m = rtttl_pkg::PH_DUR;
          else if (c == rtttl_pkg::CH_O) phase_m = rtttl_pkg::PH_OCT;
          else if (c == rtttl_pkg::CH_B) phase_m = rtttl_pkg::PH_BPM;
          else if (c == rtttl_pkg::CH_COLON) begin
            phase_m = rtttl_pkg::PH_LEN;
            plen_m  = '0;
            psemi_m = '0;
            pdot_m  = 1'b0;
            poct_m  = doct_r;
          end
        end
        rtttl_pkg::PH_DUR, rtttl_pkg::PH_OCT, rtttl_pkg::PH_BPM: begin
          if (digit) begin
            acc_m = (acc_mul > rtttl_pkg::ACC_MAX) ? rtttl_pkg::ACC_MAX[9:0] : acc_mul[9:0];
          end else if (c == rtttl_pkg::CH_COMMA || c == rtttl_pkg::CH_COLON) begin
            // commit the header value
            if (phase_r == rtttl_pkg::PH_DUR) begin
              if (acc_r != 10'd0) dlen_m = (acc_r > 10'd255) ? 8'd255 : acc_r[7:0];
            end else if (phase_r == rtttl_pkg::PH_OCT) begin
              if (acc_r >= 10'(rtttl_pkg::OCT_MIN) && acc_r <= 10'(rtttl_pkg::OCT_MAX))
                doct_m = acc_r[3:0];
            end else begin
              bpm_commit = 1'b1;
            end
            acc_m = '0;
            if (c == rtttl_pkg::CH_COMMA) begin
              phase_m = rtttl_pkg::PH_HDR;
            end else begin
              phase_m = rtttl_pkg::PH_LEN;
              plen_m  = '0;
              psemi_m = '0;
              pdot_m  = 1'b0;
              poct_m  = doct_m;
            end
          end
        end
        rtttl_pkg::PH_LEN: begin
          priority if (blank) begin
            phase_m = phase_r;
          end else if (digit) begin
            plen_m = (len_mul > rtttl_pkg::LEN_MAX) ? 8'd255 : len_mul[7:0];
          end else if (c == rtttl_pkg::CH_COMMA) begin
            plen_m = '0;
          end else if (c == rtttl_pkg::CH_X) begin
            tune_end = 1'b1;
          end else begin
            psemi_m = rtttl_pkg::semi_of(c);
            poct_m  = doct_r;
            pdot_m  = 1'b0;
            phase_m = rtttl_pkg::PH_TAIL;
          end
        end
        rtttl_pkg::PH_TAIL: begin
          priority if (c == rtttl_pkg::CH_SHARP) begin
            if (psemi_r >= 4'd1 && psemi_r <= 4'd11) psemi_m = psemi_r + 4'd1;
          end else if (c == rtttl_pkg::CH_DOT) begin
            pdot_m = 1'b1;
          end else if (digit) begin
            poct_m = dv;
          end else if (c == rtttl_pkg::CH_COMMA) begin
            emit = 1'b1;
          end else if (c == rtttl_pkg::CH_X) begin
            emit     = 1'b1;
            tune_end = 1'b1;
          end
        end
        default: phase_m = rtttl_pkg::PH_NAME;
      endcase
      // last character closes the tune
      if (in_item.last_char) begin
        tune_end = 1'b1;
        if (phase_m == rtttl_pkg::PH_TAIL) emit = 1'b1;
      end
    end
  end

  // division operands: note length or tempo
  always_comb begin
    len_sel = (plen_r != 8'd0) ? plen_r : dlen_r;
    if (len_sel == 8'd0) len_sel = 8'd1;
    div_dvd   = emit ? whole_r : rtttl_pkg::MINUTE_MS;
    div_dvs   = emit ? rtttl_pkg::DVS_W'(len_sel) : bpm_v;
    div_start = cmd.take_item && sts.need_div;
  end

  assign sts.need_div  = emit || (bpm_commit && !tune_end);
  assign sts.note_pend = note_r;
  assign sts.div_done  = div_done;

  // next state after emit and end of tune
  always_comb begin
    phase_nxt = phase_r;
    dlen_nxt  = dlen_r;
    doct_nxt  = doct_r;
    whole_nxt = whole_r;
    acc_nxt   = acc_r;
    psemi_nxt = psemi_r;
    pdot_nxt  = pdot_r;
    poct_nxt  = poct_r;
    plen_nxt  = plen_r;
    note_nxt  = note_r;
    if (cmd.write_whole) whole_nxt = {div_q[rtttl_pkg::DIV_W-3:0], 2'b00};
    if (cmd.take_item) begin
      phase_nxt = phase_m;
      dlen_nxt  = dlen_m;
      doct_nxt  = doct_m;
      acc_nxt   = acc_m;
      psemi_nxt = psemi_m;
      pdot_nxt  = pdot_m;
      poct_nxt  = poct_m;
      plen_nxt  = plen_m;
      note_nxt  = emit;
      if (emit) begin
        phase_nxt = rtttl_pkg::PH_LEN;
        plen_nxt  = '0;
        psemi_nxt = '0;
        pdot_nxt  = 1'b0;
        poct_nxt  = doct_m;
      end
      if (tune_end) begin
        phase_nxt = rtttl_pkg::PH_NAME;
        dlen_nxt  = rtttl_pkg::DEF_LEN;
        doct_nxt  = rtttl_pkg::DEF_OCT;
        whole_nxt = rtttl_pkg::WHOLE_RESET;
        acc_nxt   = '0;
        psemi_nxt = '0;
        pdot_nxt  = 1'b0;
        poct_nxt  = rtttl_pkg::DEF_OCT;
        plen_nxt  = '0;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rtttl_pkg::PH_NAME;
      dlen_r  <= rtttl_pkg::DEF_LEN;
      doct_r  <= rtttl_pkg::DEF_OCT;
      whole_r <= rtttl_pkg::WHOLE_RESET;
      acc_r   <= '0;
      psemi_r <= '0;
      pdot_r  <= 1'b0;
      poct_r  <= rtttl_pkg::DEF_OCT;
      plen_r  <= '0;
      note_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      dlen_r  <= dlen_nxt;
      doct_r  <= doct_nxt;
      whole_r <= whole_nxt;
      acc_r   <= acc_nxt;
      psemi_r <= psemi_nxt;
      pdot_r  <= pdot_nxt;
      poct_r  <= poct_nxt;
      plen_r  <= plen_nxt;
      note_r  <= note_nxt;
    end
  end

  // note fields held while the division runs
  always_ff @(posedge clk) begin
    if (cmd.take_item && emit) begin
      res_oct_r  <= poct_m + rtttl_pkg::OCTAVE_ADD;
      res_semi_r <= psemi_m;
      res_dot_r  <= pdot_m;
      res_end_r  <= tune_end;
    end
  end

  rtttl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  // dotted notes add half
  assign dur = {1'b0, div_q} + (res_dot_r ? {2'b00, div_q[rtttl_pkg::DIV_W-1:1]} : 19'd0);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.octave      <= res_oct_r;
      out_r.semitone    <= res_semi_r;
      out_r.duration_ms <= dur;
      out_r.tune_end    <= res_end_r;
    end
  end

  assign out_item = out_r;

endmodule

// ----- rtl/core/rtttl_ctrl.sv -----
module rtttl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  rtttl_pkg::dp_status_t sts,
  output rtttl_pkg::ctrl_cmd_t  cmd
);

  rtttl_pkg::ctrl_state_t state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   slot_free;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtttl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    slot_free = !out_valid_r || !out_stall;
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      rtttl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          if (sts.need_div) state_nxt = rtttl_pkg::ST_DIV;
        end
      end
      rtttl_pkg::ST_DIV: begin
        if (sts.div_done) begin
          if (!sts.note_pend) begin
            cmd.write_whole = 1'b1;
            state_nxt       = rtttl_pkg::ST_IDLE;
          end else if (slot_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = rtttl_pkg::ST_IDLE;
          end else begin
            state_nxt = rtttl_pkg::ST_HOLD;
          end
        end
      end
      rtttl_pkg::ST_HOLD: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = rtttl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rtttl_pkg::ST_IDLE;
    endcase
    out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/rtttl_checker.sv -----
`include "ringtone_text_note_parser_assert.svh"

module rtttl_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input rtttl_pkg::in_item_t  in_item,
  input logic                 out_valid,
  input logic                 out_stall,
  input rtttl_pkg::out_item_t out_item
);

  // a stalled result stays put
  `RTTTL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))

  // an ignored item never starts a division
  `RTTTL_ASSERT_NXT(a_skip_fast, clk, rst_n, in_valid && !in_stall && !in_item.play_enable, !in_stall)

  // semitone is a rest or one of twelve
  `RTTTL_ASSERT_IMP(a_semi_range, clk, rst_n, out_valid, out_item.semitone <= 4'd12)

  // longest note is a dotted whole at the slowest tempo
  `RTTTL_ASSERT_IMP(a_dur_range, clk, rst_n, out_valid, out_item.duration_ms <= 19'd360000)

endmodule

bind ringtone_text_note_parser rtttl_checker u_rtttl_checker (.*);

// ----- tb/ringtone_text_note_parser_test.sv -----
module ringtone_text_note_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rtttl_pkg::*;

  localparam int CHAR_TARGET = 450;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 60;
  localparam int SHOW_MAX    = 10;

  // tracks the parser and holds the notes it should emit
  class note_scoreboard;
    out_item_t  expected_notes[$];
    int         failures;
    phase_t     phase;
    logic [7:0] def_len;
    logic [3:0] def_oct;
    logic [17:0] whole_ms;
    int         acc;
    logic [3:0] p_semi;
    logic       p_dot;
    logic [3:0] p_oct;
    logic [7:0] p_len;

    function new();
      failures = 0;
      restart_tune();
    endfunction

    function void restart_tune();
      phase    = PH_NAME;
      def_len  = DEF_LEN;
      def_oct  = DEF_OCT;
      whole_ms = WHOLE_RESET;
      acc      = 0;
      p_semi   = 4'd0;
      p_dot    = 1'b0;
      p_oct    = DEF_OCT;
      p_len    = 8'd0;
    endfunction

    function void open_notes();
      phase  = PH_LEN;
      p_len  = 8'd0;
      p_semi = 4'd0;
      p_dot  = 1'b0;
      p_oct  = def_oct;
    endfunction

    // a finished header value takes effect
    function void close_header_value();
      int v;
      v = acc;
      case (phase)
        PH_DUR: begin
          if (v > 0) def_len = (v > 255) ? 8'd255 : 8'(v);
        end
        PH_OCT: begin
          if (v >= 3 && v <= 7) def_oct = 4'(v);
        end
        PH_BPM: begin
          if (v > 999) v = 999;
          if (v == 0) v = 63;
          whole_ms = 18'((60000 / v) * 4);
        end
        default: ;
      endcase
      acc = 0;
    endfunction

    function int pending();
      return expected_notes.size();
    endfunction

    // one accepted character
    function void take_char(in_item_t it);
      logic [7:0] c;
      logic       digit, blank, emit, done;
      int         dv, a, len, dur;
      out_item_t  note;
      if (!it.play_enable) return;
      c = it.char_code;
      if (c >= CH_UP_A && c <= CH_UP_Z) c = c | 8'h20;
      digit = (c >= CH_ZERO && c <= CH_NINE);
      dv    = digit ? int'(c - CH_ZERO) : 0;
      blank = (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF);
      emit  = 1'b0;
      done  = 1'b0;
      case (phase)
        PH_NAME: begin
          if (c == CH_COLON) phase = PH_HDR;
        end
        PH_HDR: begin
          acc = 0;
          if (c == CH_D) phase = PH_DUR;
          else if (c == CH_O) phase = PH_OCT;
          else if (c == CH_B) phase = PH_BPM;
          else if (c == CH_COLON) open_notes();
        end
        PH_DUR, PH_OCT, PH_BPM: begin
          if (digit) begin
            a = acc * 10 + dv;
            acc = (a > 999) ? 999 : a;
          end else if (c == CH_COMMA) begin
            close_header_value();
            phase = PH_HDR;
          end else if (c == CH_COLON) begin
            close_header_value();
            open_notes();
          end
        end
        PH_LEN: begin
          if (blank) begin
          end else if (digit) begin
            a = p_len * 10 + dv;
            p_len = (a > 255) ? 8'd255 : 8'(a);
          end else if (c == CH_COMMA) begin
            p_len = 8'd0;
          end else if (c == CH_X) begin
            done = 1'b1;
          end else begin
            // note letter, anything unknown is a rest
            case (c)
              CH_C:    p_semi = 4'd1;
              CH_D:    p_semi = 4'd3;
              CH_E:    p_semi = 4'd5;
              CH_F:    p_semi = 4'd6;
              CH_G:    p_semi = 4'd8;
              CH_A:    p_semi = 4'd10;
              CH_B:    p_semi = 4'd12;
              default: p_semi = 4'd0;
            endcase
            p_oct = def_oct;
            p_dot = 1'b0;
            phase = PH_TAIL;
          end
        end
        PH_TAIL: begin
          if (c == CH_SHARP) begin
            if (p_semi >= 4'd1 && p_semi <= 4'd11) p_semi = p_semi + 4'd1;
          end else if (c == CH_DOT) begin
            p_dot = 1'b1;
          end else if (digit) begin
            p_oct = 4'(dv);
          end else if (c == CH_COMMA) begin
            emit = 1'b1;
          end else if (c == CH_X) begin
            emit = 1'b1;
            done = 1'b1;
          end
        end
        default: phase = PH_NAME;
      endcase
      if (it.last_char) begin
        done = 1'b1;
        if (phase == PH_TAIL) emit = 1'b1;
      end
      if (emit) begin
        len = (p_len != 0) ? int'(p_len) : int'(def_len);
        if (len == 0) len = 1;
        dur = int'(whole_ms) / len;
        if (p_dot) dur = dur + dur / 2;
        note.octave      = p_oct + OCTAVE_ADD;
        note.semitone    = p_semi;
        note.duration_ms = 19'(dur);
        note.tune_end    = done;
        expected_notes.push_back(note);
        open_notes();
      end
      if (done) restart_tune();
    endfunction

    // one accepted note against the oldest prediction
    function void check_note(out_item_t got);
      out_item_t want;
      if (expected_notes.size() == 0) begin
        failures++;
        if (failures <= SHOW_MAX)
          $display("unexpected note: oct %0d semi %0d dur %0d end %0d",
                   got.octave, got.semitone, got.duration_ms, got.tune_end);
        return;
      end
      want = expected_notes.pop_front();
      if (got.octave !== want.octave || got.semitone !== want.semitone ||
          got.duration_ms !== want.duration_ms || got.tune_end !== want.tune_end) begin
        failures++;
        if (failures <= SHOW_MAX)
          $display({"note mismatch: expected oct %0d semi %0d dur %0d end %0d, ",
                    "got oct %0d semi %0d dur %0d end %0d"},
                   want.octave, want.semitone, want.duration_ms, want.tune_end,
                   got.octave, got.semitone, got.duration_ms, got.tune_end);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  note_scoreboard notes = new();
  in_item_t       tune_q[$];
  bit             quiet = 1'b0;
  int             burst_left = 0;
  int             char_count = 0;
  int             idle_cycles = 0;
  int             stall_left = 0;
  bit             stall_on = 1'b0;

  ringtone_text_note_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // monitor both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) notes.check_note(out_item);
      if (in_valid && !in_stall) notes.take_char(in_item);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ringtone_text_note_parser regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (!quiet && stall_left == 0) begin
      stall_on   = ($urandom_range(0, 2) == 0);
      stall_left = stall_on ? $urandom_range(1, 8) : $urandom_range(1, 20);
    end
    if (stall_left > 0) stall_left--;
    out_stall <= quiet ? 1'b0 : stall_on;
  end

  function automatic void push_ch(logic [7:0] c);
    in_item_t it;
    it.char_code   = c;
    it.last_char   = 1'b0;
    it.play_enable = 1'b1;
    tune_q.push_back(it);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_ch(s[i]);
  endfunction

  function automatic void mark_last();
    in_item_t it;
    it = tune_q.pop_back();
    it.last_char = 1'b1;
    tune_q.push_back(it);
  endfunction

  function automatic void maybe_blank();
    string blanks;
    blanks = " \t\r\n";
    if ($urandom_range(0, 9) == 0) push_ch(blanks[$urandom_range(0, 3)]);
  endfunction

  // header value for one key
  function automatic int header_value(int key);
    int r;
    r = $urandom_range(0, 5);
    case (key)
      0: begin
        if (r == 1) return 0;
        if (r == 2) return 255;
        if (r == 3) return $urandom_range(256, 1200);
        return 1 << $urandom_range(0, 5);
      end
      1: return (r != 0) ? $urandom_range(3, 7) : $urandom_range(0, 12);
      default: begin
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(1, 30);
        if (r == 2) return 999;
        if (r == 3) return $urandom_range(1000, 9999);
        return $urandom_range(40, 320);
      end
    endcase
  endfunction

  // random tune text, mostly well formed
  function automatic void build_tune();
    string      letters, rests, keys;
    int         n_keys, n_notes, key, k, ending;
    logic [7:0] c;
    in_item_t   it;
    letters = "cdefgab";
    rests   = "hijklmnqrstuvwyz";
    keys    = "dob";
    tune_q.delete();
    // name
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 2) == 0) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_COLON) c = CH_SPACE;
      end else begin
        c = letters[$urandom_range(0, 6)] & 8'hDF;
      end
      push_ch(c);
    end
    push_ch(CH_COLON);
    // header
    n_keys = $urandom_range(0, 3);
    for (int i = 0; i < n_keys; i++) begin
      key = $urandom_range(0, 2);
      maybe_blank();
      c = keys[key];
      if ($urandom_range(0, 4) == 0) c = c & 8'hDF;
      push_ch(c);
      if ($urandom_range(0, 5) != 0) push_str("=");
      push_str($sformatf("%0d", header_value(key)));
      if (i != n_keys - 1) push_ch(CH_COMMA);
    end
    push_ch(CH_COLON);
    // notes
    n_notes = $urandom_range(1, 6);
    for (int i = 0; i < n_notes; i++) begin
      maybe_blank();
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 3) == 0) push_str($sformatf("%0d", $urandom_range(0, 400)));
        else push_str($sformatf("%0d", 1 << $urandom_range(0, 5)));
      end
      k = $urandom_range(0, 9);
      if (k <= 6) c = letters[k];
      else if (k == 7) c = "p";
      else if (k == 8) c = rests[$urandom_range(0, 15)];
      else c = letters[$urandom_range(0, 6)] & 8'hDF;
      push_ch(c);
      if ($urandom_range(0, 2) == 0) push_ch(CH_SHARP);
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 2) == 0) push_ch(CH_DOT);
        if ($urandom_range(0, 1) == 0) push_ch(CH_ZERO + 8'($urandom_range(0, 9)));
      end else begin
        if ($urandom_range(0, 1) == 0) push_ch(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) push_ch(CH_DOT);
      end
      maybe_blank();
      if (i != n_notes - 1) push_ch(CH_COMMA);
      if ($urandom_range(0, 11) == 0) push_ch(CH_COMMA);
    end
    // how the tune closes
    ending = $urandom_range(0, 4);
    case (ending)
      0: begin
        push_ch(CH_COMMA);
        push_ch(($urandom_range(0, 1) == 0) ? CH_X : (CH_X & 8'hDF));
      end
      1: mark_last();
      2: begin
        push_ch(CH_COMMA);
        mark_last();
      end
      3: push_ch(CH_X);
      default: ;
    endcase
    // noise: a stray byte or a tune cut short
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, tune_q.size() - 1);
      it = tune_q[k];
      it.char_code = 8'($urandom_range(0, 255));
      tune_q[k] = it;
    end
    if ($urandom_range(0, 7) == 0) begin
      k = $urandom_range(0, tune_q.size() - 1);
      while (tune_q.size() > k + 1) void'(tune_q.pop_back());
      mark_last();
    end
  endfunction

  // one item through the input handshake, with burst gaps
  task automatic send_item(in_item_t it);
    @(negedge clk);
    if (!quiet && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_tune();
    in_item_t junk;
    foreach (tune_q[k]) begin
      if ($urandom_range(0, 11) == 0) begin
        junk.char_code   = 8'($urandom_range(0, 255));
        junk.last_char   = 1'($urandom_range(0, 1));
        junk.play_enable = 1'b0;
        send_item(junk);
      end
      send_item(tune_q[k]);
      char_count++;
    end
  endtask

  // hold off the sender until every note is out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (notes.pending() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero bpm, rejected length and octave, upper case, sharp on b,
    // dot before octave, saturated length, sharp, unknown letter, end marker
    tune_q.delete();
    push_str(":b=0,d=0,o=9:B#.7,999p,c#,h,x");
    send_tune();
    // last character inside the header
    tune_q.delete();
    push_str("zz:d");
    mark_last();
    send_tune();
    wait_drained();

    // random tunes
    while (char_count < CHAR_TARGET) begin
      quiet = ($urandom_range(0, 5) == 0);
      build_tune();
      send_tune();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (notes.failures == 0 && notes.pending() == 0) begin
      $display("ringtone_text_note_parser regression: pass");
    end else begin
      $display("ringtone_text_note_parser regression: fail");
    end
    $finish;
  end

endmodule
